>>> hw/rtl/ntt_pkg.sv
// Shared constants, types and modular helpers for the NTT engine (q = 12289).
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package ntt_pkg;

  localparam int unsigned POINTS = 1024;
  localparam int unsigned AW     = $clog2(POINTS);
  localparam int unsigned SW     = $clog2(AW);
  localparam int unsigned DW     = 14;
  localparam int unsigned IW     = 10;
  localparam int unsigned FW     = 3;
  localparam int unsigned PW     = 2 * DW;
  localparam int unsigned BAR_K  = 28;

  localparam logic [DW-1:0] Q        = 14'd12289;
  localparam logic [DW-1:0] NINV_RST = 14'd12277;
  localparam logic [14:0]   BAR_M    = 15'((64'd1 << BAR_K) / 64'd12289);

  typedef enum logic [FW-1:0] {
    FUNC_LD_FWD  = 3'd0,
    FUNC_LD_INV  = 3'd1,
    FUNC_WR_COEF = 3'd2,
    FUNC_RD_COEF = 3'd3,
    FUNC_RUN_FWD = 3'd4,
    FUNC_RUN_INV = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    MOP_FWD   = 2'd0,
    MOP_INV   = 2'd1,
    MOP_SCALE = 2'd2
  } mop_e;

  typedef enum logic [2:0] {
    WD_HOST     = 3'd0,
    WD_SUM_V    = 3'd1,
    WD_SUM_PROD = 3'd2,
    WD_DIF_PROD = 3'd3,
    WD_PROD     = 3'd4
  } wsel_e;

  typedef struct packed {
    logic [AW-1:0] raddr;
    logic [AW-1:0] twaddr;
    logic [AW-1:0] waddr;
    logic [DW-1:0] host_value;
    logic          coef_we;
    logic          twf_we;
    logic          twi_we;
    wsel_e         wsel;
    logic          cap_u;
    logic          cap_v;
    logic          tw_inv;
    mop_e          mop;
    logic          out_ld;
    logic          out_kind;
    logic          out_zero;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic [DW-1:0] reduce1(input logic [DW-1:0] x);
    return (x >= Q) ? DW'(x - Q) : x;
  endfunction

  function automatic logic [DW-1:0] addmod(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, Q}) ? DW'(s - {1'b0, Q}) : DW'(s);
  endfunction

  function automatic logic [DW-1:0] submod(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {1'b0, a} + {1'b0, Q} - {1'b0, b};
    return (s >= {1'b0, Q}) ? DW'(s - {1'b0, Q}) : DW'(s);
  endfunction

endpackage

>>> hw/rtl/ntt_if.sv
// Valid/ready channel interfaces: request, response and n_inverse write.
// Depends on ntt_pkg for field widths.
interface ntt_req_if;
  logic                       valid;
  logic                       ready;
  logic [ntt_pkg::FW-1:0]     func;
  logic [ntt_pkg::IW-1:0]     index;
  logic [ntt_pkg::DW-1:0]     value;
  modport source (output valid, func, index, value, input ready);
  modport sink   (input valid, func, index, value, output ready);
endinterface

interface ntt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [ntt_pkg::DW-1:0]     data;
  modport source (output valid, kind, data, input ready);
  modport sink   (input valid, kind, data, output ready);
endinterface

interface ntt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ntt_pkg::DW-1:0]     n_inverse;
  modport source (output valid, n_inverse, input ready);
  modport sink   (input valid, n_inverse, output ready);
endinterface

>>> hw/rtl/ntt_dp.sv
// Datapath: coefficient and twiddle memories, Barrett modular multiplier,
// butterfly add/subtract, response register and n_inverse register. Uses ntt_pkg.
module ntt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ntt_pkg::cmd_t     cmd_i,
  output ntt_pkg::stat_t    stat_o,
  ntt_cfg_if.sink           cfg_i,
  ntt_rsp_if.source         rsp_o
);

  logic [ntt_pkg::DW-1:0] coef_mem [ntt_pkg::POINTS];
  logic [ntt_pkg::DW-1:0] twf_mem  [ntt_pkg::POINTS];
  logic [ntt_pkg::DW-1:0] twi_mem  [ntt_pkg::POINTS];

  logic [ntt_pkg::DW-1:0] coef_rd_q, twf_rd_q, twi_rd_q;
  logic [ntt_pkg::DW-1:0] u_q, v_q, s_q, w_q;
  logic [ntt_pkg::DW-1:0] host_red, wdata, op_a, op_b, scale;
  logic [ntt_pkg::PW-1:0] p_q, p2_q;
  logic [14:0]            qe_q;
  logic [15:0]            r_q;
  logic [ntt_pkg::DW-1:0] ninv_q;
  logic                   out_valid_q, out_kind_q;
  logic [ntt_pkg::DW-1:0] out_data_q;

  assign host_red = ntt_pkg::reduce1(cmd_i.host_value);
  assign scale    = ntt_pkg::reduce1(ninv_q);

  always_comb begin
    unique case (cmd_i.wsel)
      ntt_pkg::WD_HOST:     wdata = host_red;
      ntt_pkg::WD_SUM_V:    wdata = ntt_pkg::addmod(u_q, v_q);
      ntt_pkg::WD_SUM_PROD: wdata = ntt_pkg::addmod(u_q, w_q);
      ntt_pkg::WD_DIF_PROD: wdata = ntt_pkg::submod(u_q, w_q);
      ntt_pkg::WD_PROD:     wdata = w_q;
      default:              wdata = host_red;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we) begin
      coef_mem[cmd_i.waddr] <= wdata;
    end
    coef_rd_q <= coef_mem[cmd_i.raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.twf_we) begin
      twf_mem[cmd_i.waddr] <= host_red;
    end
    twf_rd_q <= twf_mem[cmd_i.twaddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.twi_we) begin
      twi_mem[cmd_i.waddr] <= host_red;
    end
    twi_rd_q <= twi_mem[cmd_i.twaddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_u) begin
      u_q <= coef_rd_q;
    end
    if (cmd_i.cap_v) begin
      v_q <= coef_rd_q;
      s_q <= cmd_i.tw_inv ? twi_rd_q : twf_rd_q;
    end
  end

  always_comb begin
    unique case (cmd_i.mop)
      ntt_pkg::MOP_FWD: begin
        op_a = v_q;
        op_b = s_q;
      end
      ntt_pkg::MOP_INV: begin
        op_a = ntt_pkg::submod(u_q, v_q);
        op_b = s_q;
      end
      ntt_pkg::MOP_SCALE: begin
        op_a = u_q;
        op_b = scale;
      end
      default: begin
        op_a = v_q;
        op_b = s_q;
      end
    endcase
  end

  // Barrett reduction: product, quotient estimate, remainder, final correction
  always_ff @(posedge clk_i) begin
    p_q  <= ntt_pkg::PW'(op_a) * ntt_pkg::PW'(op_b);
    qe_q <= 15'((43'(p_q) * 43'(ntt_pkg::BAR_M)) >> ntt_pkg::BAR_K);
    p2_q <= p_q;
    r_q  <= p2_q[15:0] - 16'(30'(qe_q) * 30'(ntt_pkg::Q));
    if (r_q >= 16'(2 * 12289)) begin
      w_q <= ntt_pkg::DW'(r_q - 16'(2 * 12289));
    end else if (r_q >= 16'(ntt_pkg::Q)) begin
      w_q <= ntt_pkg::DW'(r_q - 16'(ntt_pkg::Q));
    end else begin
      w_q <= ntt_pkg::DW'(r_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ninv_q <= ntt_pkg::NINV_RST;
    end else if (cfg_i.valid) begin
      ninv_q <= cfg_i.n_inverse;
    end
  end
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_kind_q <= cmd_i.out_kind;
      out_data_q <= (cmd_i.out_kind || cmd_i.out_zero) ? '0 : coef_rd_q;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.kind      = out_kind_q;
  assign rsp_o.data      = out_data_q;
  assign stat_o.out_free = !out_valid_q || rsp_o.ready;

endmodule

>>> hw/rtl/ntt_ctrl.sv
// Controller: request decode, butterfly and scaling sequencer, address
// generation. Drives ntt_dp through ntt_pkg::cmd_t; uses ntt_pkg, ntt_if.
module ntt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  ntt_req_if.sink           req_i,
  input  ntt_pkg::stat_t    stat_i,
  output ntt_pkg::cmd_t     cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_RD1  = 13'b0000000000010,
    ST_RD2  = 13'b0000000000100,
    ST_RA   = 13'b0000000001000,
    ST_RB   = 13'b0000000010000,
    ST_RC   = 13'b0000000100000,
    ST_MA   = 13'b0000001000000,
    ST_MB   = 13'b0000010000000,
    ST_MC   = 13'b0000100000000,
    ST_MD   = 13'b0001000000000,
    ST_WU   = 13'b0010000000000,
    ST_WV   = 13'b0100000000000,
    ST_FIN  = 13'b1000000000000
  } state_e;

  state_e                 state_q, state_d;
  logic [ntt_pkg::AW-1:0] idx_q, idx_d, cnt_q, cnt_d;
  logic [ntt_pkg::SW-1:0] stage_q, stage_d, lt;
  logic                   in_range_q, in_range_d, inv_q, inv_d, scl_q, scl_d;
  logic                   in_range;
  logic [ntt_pkg::AW-1:0] addr, kx, mask, hi, j, jt, tw;
  logic                   last_bf;

  assign in_range = 32'(req_i.index) < ntt_pkg::POINTS;
  assign addr     = ntt_pkg::AW'(req_i.index);
  assign req_i.ready = (state_q == ST_IDLE);

  assign kx   = {1'b0, cnt_q[ntt_pkg::AW-2:0]};
  assign lt   = inv_q ? stage_q : ntt_pkg::SW'(ntt_pkg::AW - 1) - stage_q;
  assign mask = (ntt_pkg::AW'(1) << lt) - ntt_pkg::AW'(1);
  assign hi   = kx >> lt;
  assign j    = (hi << (lt + ntt_pkg::SW'(1))) | (kx & mask);
  assign jt   = j | (ntt_pkg::AW'(1) << lt);
  assign tw   = inv_q ? (ntt_pkg::AW'(ntt_pkg::POINTS / 2) >> stage_q) + hi
                      : (ntt_pkg::AW'(1) << stage_q) + hi;
  assign last_bf = &cnt_q[ntt_pkg::AW-2:0];

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    stage_d    = stage_q;
    in_range_d = in_range_q;
    inv_d      = inv_q;
    scl_d      = scl_q;

    cmd_o            = '0;
    cmd_o.raddr      = idx_q;
    cmd_o.twaddr     = tw;
    cmd_o.waddr      = addr;
    cmd_o.host_value = req_i.value;
    cmd_o.wsel       = ntt_pkg::WD_HOST;
    cmd_o.tw_inv     = inv_q;
    cmd_o.mop        = scl_q ? ntt_pkg::MOP_SCALE
                     : (inv_q ? ntt_pkg::MOP_INV : ntt_pkg::MOP_FWD);

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (ntt_pkg::func_e'(req_i.func))
            ntt_pkg::FUNC_LD_FWD:  cmd_o.twf_we  = in_range;
            ntt_pkg::FUNC_LD_INV:  cmd_o.twi_we  = in_range;
            ntt_pkg::FUNC_WR_COEF: cmd_o.coef_we = in_range;
            ntt_pkg::FUNC_RD_COEF: begin
              idx_d      = addr;
              in_range_d = in_range;
              state_d    = ST_RD1;
            end
            ntt_pkg::FUNC_RUN_FWD, ntt_pkg::FUNC_RUN_INV: begin
              inv_d   = (ntt_pkg::func_e'(req_i.func) == ntt_pkg::FUNC_RUN_INV);
              scl_d   = 1'b0;
              cnt_d   = '0;
              stage_d = '0;
              state_d = ST_RA;
            end
            default: ;
          endcase
        end
      end
      ST_RD1: state_d = ST_RD2;
      ST_RD2: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_zero = !in_range_q;
          state_d        = ST_IDLE;
        end
      end
      ST_RA: begin
        cmd_o.raddr = scl_q ? cnt_q : j;
        state_d     = ST_RB;
      end
      ST_RB: begin
        cmd_o.raddr = jt;
        cmd_o.cap_u = 1'b1;
        state_d     = scl_q ? ST_MA : ST_RC;
      end
      ST_RC: begin
        cmd_o.cap_v = 1'b1;
        state_d     = ST_MA;
      end
      ST_MA: state_d = ST_MB;
      ST_MB: state_d = ST_MC;
      ST_MC: state_d = ST_MD;
      ST_MD: state_d = ST_WU;
      ST_WU: begin
        cmd_o.coef_we = 1'b1;
        cmd_o.waddr   = scl_q ? cnt_q : j;
        cmd_o.wsel    = scl_q ? ntt_pkg::WD_PROD
                      : (inv_q ? ntt_pkg::WD_SUM_V : ntt_pkg::WD_SUM_PROD);
        if (!scl_q) begin
          state_d = ST_WV;
        end else if (&cnt_q) begin
          state_d = ST_FIN;
        end else begin
          cnt_d   = cnt_q + ntt_pkg::AW'(1);
          state_d = ST_RA;
        end
      end
      ST_WV: begin
        cmd_o.coef_we = 1'b1;
        cmd_o.waddr   = jt;
        cmd_o.wsel    = inv_q ? ntt_pkg::WD_PROD : ntt_pkg::WD_DIF_PROD;
        state_d       = ST_RA;
        if (!last_bf) begin
          cnt_d = cnt_q + ntt_pkg::AW'(1);
        end else begin
          cnt_d = '0;
          if (stage_q == ntt_pkg::SW'(ntt_pkg::AW - 1)) begin
            if (inv_q) begin
              scl_d = 1'b1;
            end else begin
              state_d = ST_FIN;
            end
          end else begin
            stage_d = stage_q + ntt_pkg::SW'(1);
          end
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_kind = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      cnt_q      <= '0;
      stage_q    <= '0;
      in_range_q <= 1'b0;
      inv_q      <= 1'b0;
      scl_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      stage_q    <= stage_d;
      in_range_q <= in_range_d;
      inv_q      <= inv_d;
      scl_q      <= scl_d;
    end
  end

endmodule

>>> hw/rtl/ntt_forward_inverse_q12289.sv
// Top level of the NTT engine modulo 12289: controller plus datapath.
// Depends on ntt_pkg, ntt_if, ntt_ctrl and ntt_dp.
//
// Channels: req_i carries func/index/value beats; rsp_o returns kind/data
// beats (kind 0 read data, kind 1 transform done with data zero); cfg_i
// writes n_inverse and is always ready.
// Load and write beats return nothing. A read beat passes ST_RD1 and ST_RD2,
// leaving ST_RD2 once the output register is free. A forward run takes each
// butterfly through ST_RA, ST_RB, ST_RC, ST_MA to ST_MD, ST_WU and ST_WV; an
// inverse run adds an n_inverse scaling pass per coefficient through ST_RA,
// ST_RB, ST_MA to ST_MD and ST_WU. This order comes from the single coefficient
// memory read and write port and the four-stage Barrett multiplier each butterfly waits on.
// req_i.ready is high only while no item is in progress; a new request is
// taken while a response still waits on rsp_o, but the next response holds
// until the receiver frees the output register.
// Reset clears the controller and the response valid flag and sets n_inverse to
// 12277; the memories hold no reset value and must be written before use.
module ntt_forward_inverse_q12289 (
  input  logic      clk_i,
  input  logic      rst_ni,
  ntt_req_if.sink   req_i,
  ntt_rsp_if.source rsp_o,
  ntt_cfg_if.sink   cfg_i
);

  ntt_pkg::cmd_t  cmd;
  ntt_pkg::stat_t stat;

  ntt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  ntt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_i  (cfg_i),
    .rsp_o  (rsp_o)
  );

  a_done_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.kind |-> rsp_o.data == '0)
    else $error("done beat carries nonzero data");

  a_data_canon : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.kind && !$isunknown(rsp_o.data) |-> rsp_o.data < ntt_pkg::Q)
    else $error("read data not a canonical residue");

  a_run_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready &&
    (req_i.func == ntt_pkg::FUNC_RUN_FWD || req_i.func == ntt_pkg::FUNC_RUN_INV)
    |=> !req_i.ready)
    else $error("engine took a beat right after starting a run");

  a_load_only_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> stat.out_free)
    else $error("response register overwritten");

endmodule

>>> test/ntt_forward_inverse_q12289_tb.sv
// Testbench for the NTT engine modulo 12289: loads, coefficient access and transform runs.
// Self-checking against a built-in transform predictor; depends on ntt_pkg, ntt_if and ntt_forward_inverse_q12289.
module ntt_forward_inverse_q12289_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntt_pkg::*;

  localparam logic [FW-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FW-1:0] FUNC_SPARE7 = 3'd7;
  localparam int unsigned MODQ = 12289;
  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 390;
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic          kind;
    logic [DW-1:0] data;
  } beat_t;

  typedef struct {
    logic [FW-1:0] func;
    logic [IW-1:0] index;
    logic [DW-1:0] value;
    logic          typed;
    beat_t         want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  ntt_req_if req ();
  ntt_rsp_if rsp ();
  ntt_cfg_if cfg ();

  ntt_forward_inverse_q12289 dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  logic [DW-1:0] coef_m [POINTS];
  logic [DW-1:0] twf_m [POINTS];
  logic [DW-1:0] twi_m [POINTS];
  int unsigned   n_inv_m;
  beat_t         pending_q [$];
  int unsigned   errors;
  int unsigned   idle_cycles;
  int unsigned   burst_left;
  logic          tag_typed;
  beat_t         tag_want;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [DW-1:0] mulq(int unsigned a, int unsigned b);
    return DW'((a * b) % MODQ);
  endfunction

  function automatic void transform_forward();
    int unsigned t;
    int unsigned base;
    int unsigned s;
    int unsigned u;
    int unsigned v;
    t = POINTS;
    for (int unsigned m = 1; m < POINTS; m <<= 1) begin
      t >>= 1;
      for (int unsigned i = 0; i < m; i++) begin
        base = 2 * i * t;
        s = twf_m[m + i];
        for (int unsigned j = base; j < base + t; j++) begin
          u = coef_m[j];
          v = mulq(coef_m[j + t], s);
          coef_m[j] = DW'((u + v) % MODQ);
          coef_m[j + t] = DW'((u + MODQ - v) % MODQ);
        end
      end
    end
  endfunction

  function automatic void transform_inverse();
    int unsigned t;
    int unsigned h;
    int unsigned base;
    int unsigned s;
    int unsigned u;
    int unsigned v;
    t = 1;
    for (int unsigned m = POINTS; m > 1; m >>= 1) begin
      h = m >> 1;
      base = 0;
      for (int unsigned i = 0; i < h; i++) begin
        s = twi_m[h + i];
        for (int unsigned j = base; j < base + t; j++) begin
          u = coef_m[j];
          v = coef_m[j + t];
          coef_m[j] = DW'((u + v) % MODQ);
          coef_m[j + t] = mulq((u + MODQ - v) % MODQ, s);
        end
        base += 2 * t;
      end
      t <<= 1;
    end
    for (int unsigned j = 0; j < POINTS; j++) coef_m[j] = mulq(coef_m[j], n_inv_m % MODQ);
  endfunction

  function automatic void predict_beat(logic [FW-1:0] f, logic [IW-1:0] idx, logic [DW-1:0] val);
    logic [DW-1:0] r;
    r = DW'(int'(val) % MODQ);
    case (f)
      FUNC_LD_FWD:  twf_m[idx] = r;
      FUNC_LD_INV:  twi_m[idx] = r;
      FUNC_WR_COEF: coef_m[idx] = r;
      FUNC_RD_COEF: pending_q.push_back('{kind: KIND_READ, data: coef_m[idx]});
      FUNC_RUN_FWD: begin
        transform_forward();
        pending_q.push_back('{kind: KIND_DONE, data: '0});
      end
      FUNC_RUN_INV: begin
        transform_inverse();
        pending_q.push_back('{kind: KIND_DONE, data: '0});
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        predict_beat(req.func, req.index, req.value);
        if (tag_typed && pending_q.size() > 0) pending_q[$] = tag_want;
      end
      if (cfg.valid && cfg.ready) n_inv_m = cfg.n_inverse;
      if (rsp.valid && rsp.ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected beat kind %0d data %0d", $time, rsp.kind, rsp.data);
          errors++;
        end else begin
          beat_t w;
          w = pending_q.pop_front();
          if (w.kind !== rsp.kind) begin
            $display("%0t: kind exp %0d got %0d", $time, w.kind, rsp.kind);
            errors++;
          end
          if (w.data !== rsp.data) begin
            $display("%0t: data exp %0d got %0d", $time, w.data, rsp.data);
            errors++;
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("ntt_forward_inverse_q12289_tb NOT OK");
        $finish;
      end
    end
  end

  int unsigned cyc;
  int unsigned stall_mode;
  int unsigned stall_cnt;
  always @(posedge clk_i) begin
    cyc++;
    if (cyc % 256 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_cnt > 0) begin
          stall_cnt--;
          rsp.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_cnt = $urandom_range(1, 40);
          rsp.ready <= 1'b0;
        end else begin
          rsp.ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic issue(logic [FW-1:0] f, logic [IW-1:0] idx, logic [DW-1:0] val,
                       logic typed = 1'b0, beat_t want = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.func  <= f;
    req.index <= idx;
    req.value <= val;
    tag_typed <= typed;
    tag_want  <= want;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    while (pending_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_n_inverse(logic [DW-1:0] v);
    cfg.valid     <= 1'b1;
    cfg.n_inverse <= v;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) issue(FUNC_WR_COEF, IW'($urandom), DW'($urandom));
    else if (r < 62) issue(FUNC_RD_COEF, IW'($urandom), DW'($urandom));
    else if (r < 75) issue(FUNC_LD_FWD, IW'($urandom), DW'($urandom));
    else if (r < 88) issue(FUNC_LD_INV, IW'($urandom), DW'($urandom));
    else if (r < 94) issue(r[0] ? FUNC_SPARE6 : FUNC_SPARE7, IW'($urandom), DW'($urandom));
    else issue(FUNC_WR_COEF, IW'($urandom), DW'($urandom_range(0, MODQ - 1)));
  endtask

  row_t rows [$];
  logic [DW-1:0] ninv_set [4];

  initial begin
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    n_inv_m = NINV_RST;
    stall_mode = 0;
    stall_cnt = 0;
    cyc = 0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.func = '0;
    req.index = '0;
    req.value = '0;
    rsp.ready = 1'b1;
    cfg.valid = 1'b0;
    cfg.n_inverse = '0;
    tag_typed = 1'b0;
    tag_want = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every store so no unwritten entry is ever used
    for (int i = 0; i < POINTS; i++) issue(FUNC_LD_FWD, IW'(i), DW'($urandom));
    for (int i = 0; i < POINTS; i++) issue(FUNC_LD_INV, IW'(i), DW'($urandom));
    for (int i = 0; i < POINTS; i++) issue(FUNC_WR_COEF, IW'(i), DW'($urandom));

    rows = '{
      '{FUNC_WR_COEF, 10'd0,    14'd0,     1'b0, '0},
      '{FUNC_RD_COEF, 10'd0,    14'd0,     1'b1, '{KIND_READ, 14'd0}},
      '{FUNC_WR_COEF, 10'd1023, 14'd12288, 1'b0, '0},
      '{FUNC_RD_COEF, 10'd1023, 14'd0,     1'b1, '{KIND_READ, 14'd12288}},
      '{FUNC_WR_COEF, 10'd682,  14'd16383, 1'b0, '0},
      '{FUNC_RD_COEF, 10'd682,  14'd0,     1'b1, '{KIND_READ, 14'd4094}},
      '{FUNC_WR_COEF, 10'd341,  14'd12289, 1'b0, '0},
      '{FUNC_RD_COEF, 10'd341,  14'd16383, 1'b1, '{KIND_READ, 14'd0}},
      '{FUNC_WR_COEF, 10'd5,    14'd8191,  1'b0, '0},
      '{FUNC_RD_COEF, 10'd5,    14'd0,     1'b1, '{KIND_READ, 14'd8191}},
      '{FUNC_LD_FWD,  10'd0,    14'd16383, 1'b0, '0},
      '{FUNC_LD_FWD,  10'd1023, 14'd0,     1'b0, '0},
      '{FUNC_LD_INV,  10'd0,    14'd12289, 1'b0, '0},
      '{FUNC_LD_INV,  10'd1023, 14'd12288, 1'b0, '0},
      '{FUNC_SPARE6,  10'd3,    14'd7,     1'b0, '0},
      '{FUNC_SPARE7,  10'd1023, 14'd16383, 1'b0, '0},
      '{FUNC_RD_COEF, 10'd1023, 14'd0,     1'b1, '{KIND_READ, 14'd12288}},
      '{FUNC_RUN_FWD, 10'd0,    14'd0,     1'b1, '{KIND_DONE, 14'd0}},
      '{FUNC_RD_COEF, 10'd0,    14'd0,     1'b0, '0},
      '{FUNC_RD_COEF, 10'd512,  14'd0,     1'b0, '0},
      '{FUNC_RUN_INV, 10'd0,    14'd0,     1'b1, '{KIND_DONE, 14'd0}},
      '{FUNC_RD_COEF, 10'd1023, 14'd0,     1'b0, '0},
      '{FUNC_RD_COEF, 10'd1,    14'd0,     1'b0, '0}
    };
    foreach (rows[k]) issue(rows[k].func, rows[k].index, rows[k].value, rows[k].typed, rows[k].want);
    drain();

    ninv_set[0] = 14'd0;
    ninv_set[1] = 14'd12288;
    ninv_set[2] = 14'd16383;
    ninv_set[3] = DW'($urandom);
    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_n_inverse(ninv_set[p - 1]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 3 || k == 2 * PHASE_ITEMS / 3)
          issue($urandom_range(0, 1) ? FUNC_RUN_FWD : FUNC_RUN_INV, IW'($urandom), DW'($urandom));
        else
          random_item();
      end
      drain();
    end

    if (errors == 0)
      $display("ntt_forward_inverse_q12289_tb OK");
    else
      $display("ntt_forward_inverse_q12289_tb NOT OK");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ntt_pkg.sv
hw/rtl/ntt_if.sv
hw/rtl/ntt_dp.sv
hw/rtl/ntt_ctrl.sv
hw/rtl/ntt_forward_inverse_q12289.sv
test/ntt_forward_inverse_q12289_tb.sv
